/* src/assert_macros.svh */
// assertion macros, compiled out under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/bwme_pkg.sv */
// ----------------------------------------------------------------------------
// bwme_pkg
// types, constants and fixed-point helpers of the bone world matrix engine
// ----------------------------------------------------------------------------
package bwme_pkg;
  localparam int NUM_BONES_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic [5:0]         bone_index;
    logic [6:0]         parent_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } bone_in_t;

  typedef struct packed {
    logic [1:0]         row_number;
    logic signed [31:0] elem_0;
    logic signed [31:0] elem_1;
    logic signed [31:0] elem_2;
    logic signed [31:0] elem_3;
    logic               last_row;
  } row_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_QPROD, ST_ROT, ST_LOCAL, ST_RDPAR, ST_WORLD, ST_EMIT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7fffffff;
    else if (v < -36'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // counter divided by three, exact for 0..63
  function automatic logic [5:0] div3(input logic [5:0] v);
    logic [11:0] t;
    t = 12'(v) * 12'd43;
    return {1'b0, t[11:7]};
  endfunction

  function automatic logic [5:0] mod3(input logic [5:0] v);
    return v - div3(v) * 6'd3;
  endfunction
endpackage

/* src/bone_world_matrix_engine.sv */
// ----------------------------------------------------------------------------
// bone_world_matrix_engine
// local trs matrix per bone, times parent world matrix from ram, four rows out
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  in      | in  | in_valid/in_ready   | bone_in_t
//  out     | out | out_valid/out_ready | row_out_t, four transfers per bone
//
//  one shared 32x32 multiplier, one product per cycle, registered
//  steps per bone, in order: accept, quaternion (9 products), rotation,
//  local (9 products), parent reads (12 words), world (36 products),
//  emit writing the 12 world words; row 3 waits for the last write
//  reset clears control only; world ram is undefined until written
//  output stalls hold the engine only after a bone's rows are ready
module bone_world_matrix_engine
  import bwme_pkg::*;
#(
  parameter int NUM_BONES = NUM_BONES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bwme_pkg::bone_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bwme_pkg::row_out_t  out_data
);
  `include "assert_macros.svh"

  localparam int DEPTH = NUM_BONES * 12;
  localparam int AW = $clog2(DEPTH);
  localparam int BW = $clog2(NUM_BONES);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  state_t state_r, state_nxt;
  bone_in_t item_r;
  logic [5:0] cnt_r, cnt_nxt;
  logic [1:0] row_r;
  logic signed [31:0] q_r [10];
  logic signed [31:0] rot_r [9];
  logic signed [31:0] loc_r [9];
  logic signed [31:0] par_r [12];
  logic signed [31:0] wld_r [12];
  logic signed [35:0] acc_r;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod_r;
  logic mvld_r;
  logic [5:0] mtag_r;
  logic signed [31:0] mres;
  logic is_root, bone_ok;
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0] ram_rdata;
  logic rd_vld_r;
  logic [3:0] rd_idx_r;

  assign is_root = ({25'd0, item_r.parent_index} >= NUM_BONES);
  assign bone_ok = ({26'd0, item_r.bone_index} < NUM_BONES);

  // rounded, saturated product of the registered multiplier output
  always_comb begin
    logic signed [63:0] p;
    logic signed [63:0] s;
    p = prod_r + HALF;
    s = p >>> FRAC_BITS;
    if (s > 64'sd2147483647) mres = 32'sh7fffffff;
    else if (s < -64'sd2147483648) mres = 32'sh80000000;
    else mres = s[31:0];
  end

  // operand selection
  always_comb begin
    logic signed [31:0] qv [4];
    logic signed [31:0] sc [3];
    logic [3:0] r, k, c;
    qv[0] = item_r.quat_x; qv[1] = item_r.quat_y;
    qv[2] = item_r.quat_z; qv[3] = item_r.quat_w;
    sc[0] = item_r.scale_x; sc[1] = item_r.scale_y; sc[2] = item_r.scale_z;
    ma = '0;
    mb = '0;
    r = '0; k = '0; c = '0;
    case (state_r)
      ST_QPROD: begin
        // xx yy zz xy xz yz xw yw zw
        case (cnt_r)
          6'd0: begin ma = qv[0]; mb = qv[0]; end
          6'd1: begin ma = qv[1]; mb = qv[1]; end
          6'd2: begin ma = qv[2]; mb = qv[2]; end
          6'd3: begin ma = qv[0]; mb = qv[1]; end
          6'd4: begin ma = qv[0]; mb = qv[2]; end
          6'd5: begin ma = qv[1]; mb = qv[2]; end
          6'd6: begin ma = qv[0]; mb = qv[3]; end
          6'd7: begin ma = qv[1]; mb = qv[3]; end
          6'd8: begin ma = qv[2]; mb = qv[3]; end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      ST_LOCAL: begin
        // loc[r][c] = s_c * rot[c][r], index cnt = r*3+c
        r = 4'(div3(cnt_r));
        c = 4'(mod3(cnt_r));
        if (cnt_r < 6'd9) begin
          ma = sc[c[1:0]];
          mb = rot_r[c * 3 + r];
        end
      end
      ST_WORLD: begin
        // cnt = (r*4+c)*3+k
        r = 4'(div3(cnt_r) >> 2);
        c = 4'(div3(cnt_r) & 6'd3);
        k = 4'(mod3(cnt_r));
        if (cnt_r < 6'd36) begin
          ma = par_r[r * 4 + k];
          if (c == 4'd3) begin
            case (k)
              4'd0: mb = item_r.pos_x;
              4'd1: mb = item_r.pos_y;
              default: mb = item_r.pos_z;
            endcase
          end else begin
            mb = loc_r[k * 3 + c];
          end
        end
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(ma) * 64'(mb);
    mtag_r <= cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvld_r <= 1'b0;
    end else begin
      mvld_r <= (state_r == ST_QPROD && cnt_r < 6'd9) ||
                (state_r == ST_LOCAL && cnt_r < 6'd9) ||
                (state_r == ST_WORLD && cnt_r < 6'd36);
    end
  end

  // ram port: reads of the parent rows, then writes of the world rows
  always_comb begin
    ram_we = 1'b0;
    ram_addr = '0;
    if (state_r == ST_RDPAR && cnt_r < 6'd12) begin
      ram_addr = AW'(item_r.parent_index[BW-1:0] * 12 + cnt_r);
    end else if (state_r == ST_EMIT && cnt_r < 6'd12) begin
      ram_we = bone_ok;
      ram_addr = AW'(item_r.bone_index[BW-1:0] * 12 + cnt_r);
    end
  end

  bwme_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (wld_r[cnt_r[3:0]]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_QPROD;
          cnt_nxt = '0;
        end
      end
      ST_QPROD: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd9) begin
          state_nxt = ST_ROT;
          cnt_nxt = '0;
        end
      end
      ST_ROT: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd8) begin
          state_nxt = ST_LOCAL;
          cnt_nxt = '0;
        end
      end
      ST_LOCAL: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd9) begin
          state_nxt = ST_RDPAR;
          cnt_nxt = '0;
        end
      end
      ST_RDPAR: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd12) begin
          state_nxt = ST_WORLD;
          cnt_nxt = '0;
        end
      end
      ST_WORLD: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd36) begin
          state_nxt = ST_EMIT;
          cnt_nxt = '0;
        end
      end
      ST_EMIT: begin
        if (cnt_r < 6'd12) cnt_nxt = cnt_r + 6'd1;
        if (out_valid && out_ready && row_r == 2'd3) begin
          state_nxt = ST_IDLE;
          cnt_nxt = '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      row_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      rd_vld_r <= (state_r == ST_RDPAR && cnt_r < 6'd12);
      if (out_valid && out_ready) row_r <= row_r + 2'd1;
      else if (state_r != ST_EMIT) row_r <= '0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    logic signed [35:0] e;
    logic [3:0] ri, ci;
    if (state_r == ST_IDLE && in_valid) item_r <= in_data;
    rd_idx_r <= cnt_r[3:0];
    if (mvld_r && state_r == ST_QPROD) q_r[mtag_r[3:0]] <= mres;
    if (state_r == ST_ROT) begin
      // q: 0 xx 1 yy 2 zz 3 xy 4 xz 5 yz 6 xw 7 yw 8 zw
      case (cnt_r)
        6'd0: e = 36'(ONE) - 2 * (36'(q_r[1]) + 36'(q_r[2]));
        6'd1: e = 2 * (36'(q_r[3]) + 36'(q_r[8]));
        6'd2: e = 2 * (36'(q_r[4]) - 36'(q_r[7]));
        6'd3: e = 2 * (36'(q_r[3]) - 36'(q_r[8]));
        6'd4: e = 36'(ONE) - 2 * (36'(q_r[0]) + 36'(q_r[2]));
        6'd5: e = 2 * (36'(q_r[5]) + 36'(q_r[6]));
        6'd6: e = 2 * (36'(q_r[4]) + 36'(q_r[7]));
        6'd7: e = 2 * (36'(q_r[5]) - 36'(q_r[6]));
        default: e = 36'(ONE) - 2 * (36'(q_r[0]) + 36'(q_r[1]));
      endcase
      rot_r[cnt_r[3:0]] <= sat32(e);
    end
    if (mvld_r && state_r == ST_LOCAL) loc_r[mtag_r[3:0]] <= mres;
    if (rd_vld_r) begin
      ri = 4'(rd_idx_r / 4);
      ci = 4'(rd_idx_r % 4);
      if (is_root) par_r[rd_idx_r] <= (ri == ci) ? ONE : 32'sd0;
      else par_r[rd_idx_r] <= ram_rdata;
    end
    if (mvld_r && state_r == ST_WORLD) begin
      e = acc_r + 36'(mres);
      if (mod3(mtag_r) == 6'd0) begin
        e = 36'(mres);
        if ((div3(mtag_r) & 6'd3) == 6'd3) e = e + 36'(par_r[(div3(mtag_r) >> 2) * 4 + 3]);
      end
      acc_r <= e;
      if (mod3(mtag_r) == 6'd2) wld_r[4'(div3(mtag_r))] <= sat32(e);
    end
  end

  always_comb begin
    out_valid = (state_r == ST_EMIT) && !(row_r == 2'd3 && cnt_r < 6'd11);
    out_data.row_number = row_r;
    out_data.last_row = (row_r == 2'd3);
    if (row_r == 2'd3) begin
      out_data.elem_0 = '0;
      out_data.elem_1 = '0;
      out_data.elem_2 = '0;
      out_data.elem_3 = ONE;
    end else begin
      out_data.elem_0 = wld_r[row_r * 4 + 0];
      out_data.elem_1 = wld_r[row_r * 4 + 1];
      out_data.elem_2 = wld_r[row_r * 4 + 2];
      out_data.elem_3 = wld_r[row_r * 4 + 3];
    end
  end

  `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, state_r == ST_IDLE)
  `ASSERT_IMPL(a_we_emit, clk, rst_n, ram_we, state_r == ST_EMIT)
  `ASSERT_IMPL(a_last_row, clk, rst_n, out_valid && out_data.last_row,
               out_data.row_number == 2'd3)
  `ASSERT_NEXT(a_done, clk, rst_n, out_valid && out_ready && out_data.last_row,
               state_r == ST_IDLE)
endmodule

/* src/bwme_ram.sv */
// ----------------------------------------------------------------------------
// bwme_ram
// generic single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module bwme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// checks the bone world matrix engine: each bone transfer is predicted in
// fixed point (local trs matrix times the stored parent world matrix) and the
// four row transfers that come back are compared as whole structs, in order
// ----------------------------------------------------------------------------
module tb;
  import bwme_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = 64;
  localparam int FB = 16;
  localparam longint ONE = 64'sd1 << FB;
  localparam logic [6:0] ROOT = 7'd64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bone_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  row_out_t out_data;

  bone_world_matrix_engine uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  row_out_t expected_rows[$];
  longint world_rows[NB][3][4];
  bit written[NB];
  int mismatches = 0;
  bit idle_on = 1'b1;

  function automatic longint sat(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fmul(input longint a, input longint b);
    longint p;
    p = a * b + (64'sd1 << (FB - 1));
    return sat(p >>> FB);
  endfunction

  task automatic predict_bone(input bone_in_t b);
    longint x, y, z, w, rot[3][3], loc[3][4], par[3][4], wld[3][4], acc;
    longint s[3], pos[3];
    row_out_t row;
    pos = '{b.pos_x, b.pos_y, b.pos_z};
    s = '{b.scale_x, b.scale_y, b.scale_z};
    x = b.quat_x; y = b.quat_y; z = b.quat_z; w = b.quat_w;
    rot[0][0] = sat(ONE - 2 * (fmul(y, y) + fmul(z, z)));
    rot[0][1] = sat(2 * (fmul(x, y) + fmul(z, w)));
    rot[0][2] = sat(2 * (fmul(x, z) - fmul(y, w)));
    rot[1][0] = sat(2 * (fmul(x, y) - fmul(z, w)));
    rot[1][1] = sat(ONE - 2 * (fmul(x, x) + fmul(z, z)));
    rot[1][2] = sat(2 * (fmul(y, z) + fmul(x, w)));
    rot[2][0] = sat(2 * (fmul(x, z) + fmul(y, w)));
    rot[2][1] = sat(2 * (fmul(y, z) - fmul(x, w)));
    rot[2][2] = sat(ONE - 2 * (fmul(x, x) + fmul(y, y)));
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) loc[r][c] = fmul(s[c], rot[c][r]);
      loc[r][3] = pos[r];
      for (int c = 0; c < 4; c++)
        par[r][c] = (b.parent_index < NB) ? world_rows[b.parent_index][r][c]
                                          : ((r == c) ? ONE : 0);
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) begin
        acc = (c == 3) ? par[r][3] : 0;
        for (int k = 0; k < 3; k++) acc += fmul(par[r][k], loc[k][c]);
        wld[r][c] = sat(acc);
      end
    if (b.bone_index < NB) begin
      world_rows[b.bone_index] = wld;
      written[b.bone_index] = 1'b1;
    end
    for (int r = 0; r < 4; r++) begin
      row.row_number = 2'(r);
      row.elem_0 = (r < 3) ? 32'(wld[r][0]) : '0;
      row.elem_1 = (r < 3) ? 32'(wld[r][1]) : '0;
      row.elem_2 = (r < 3) ? 32'(wld[r][2]) : '0;
      row.elem_3 = (r < 3) ? 32'(wld[r][3]) : 32'(ONE);
      row.last_row = (r == 3);
      expected_rows = {expected_rows, row};
    end
  endtask

  task automatic send_bone(input bone_in_t b);
    if (idle_on && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 9)) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_bone(b);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_rows.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n || !idle_on) out_ready <= rst_n;
    else if (out_ready) out_ready <= ($urandom_range(0, 5) != 0);
    else out_ready <= ($urandom_range(0, 2) == 0);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row transfer %p", out_data);
      end else begin
        row_out_t e;
        e = expected_rows.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("row mismatch exp %p got %p", e, out_data);
        end
      end
    end
  end

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(0, 2 * 65536)) - 65536;
    endcase
  endfunction

  function automatic bone_in_t rnd_bone(input logic [5:0] idx, input logic [6:0] par);
    bone_in_t b;
    b.bone_index = idx; b.parent_index = par;
    b.pos_x = rnd_val(); b.pos_y = rnd_val(); b.pos_z = rnd_val();
    b.quat_x = rnd_val(); b.quat_y = rnd_val(); b.quat_z = rnd_val();
    b.quat_w = rnd_val();
    b.scale_x = rnd_val(); b.scale_y = rnd_val(); b.scale_z = rnd_val();
    return b;
  endfunction

  function automatic logic [6:0] rnd_parent();
    int tries;
    logic [6:0] p;
    if ($urandom_range(0, 4) == 0) return 7'($urandom_range(64, 127));
    for (tries = 0; tries < 20; tries++) begin
      p = 7'($urandom_range(0, 63));
      if (written[p]) return p;
    end
    return ROOT;
  endfunction

  task automatic test_directed();
    bone_in_t b;
    b = '0;
    b.parent_index = ROOT; b.quat_w = 32'(ONE);
    b.scale_x = 32'(ONE); b.scale_y = 32'(ONE); b.scale_z = 32'(ONE);
    send_bone(b);
    b.bone_index = 6'd63; b.pos_x = 32'h7fffffff; b.pos_y = 32'h80000000;
    b.pos_z = -32'sd1;
    send_bone(b);
    b.bone_index = 6'd1; b.parent_index = 7'd0; send_bone(b);
    b.bone_index = 6'd2; b.parent_index = 7'd63; b.quat_x = 32'sd46341;
    b.quat_w = 32'sd46341; send_bone(b);
    b.bone_index = 6'd2; b.parent_index = 7'd2; send_bone(b);
    b.bone_index = 6'd3; b.parent_index = 7'd127; b.quat_x = 32'h7fffffff;
    b.quat_y = 32'h80000000; b.quat_z = 32'h7fffffff; b.quat_w = 32'h80000000;
    b.scale_x = 32'h7fffffff; b.scale_y = 32'h80000000; b.scale_z = '0;
    send_bone(b);
    b = '1; b.parent_index = 7'd3; send_bone(b);
    b.bone_index = 6'd4; b.parent_index = 7'd63; send_bone(b);
    for (int i = 0; i < 8; i++) send_bone(rnd_bone(6'($urandom), rnd_parent()));
  endtask

  task automatic test_pause();
    wait_drained();
    send_bone(rnd_bone(6'($urandom), rnd_parent()));
  endtask

  task automatic test_chains(input int n);
    logic [5:0] idx;
    logic [6:0] par;
    for (int i = 0; i < n; i++) begin
      idx = 6'($urandom);
      par = (i % 6 == 0) ? ROOT : rnd_parent();
      send_bone(rnd_bone(idx, par));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pause();
    test_chains(150);
    idle_on = 1'b0;
    test_chains(45);
    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_rows.size() == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end
endmodule

/* bone_world_matrix_engine.f */
+incdir+src
src/bwme_pkg.sv
src/bwme_ram.sv
src/bone_world_matrix_engine.sv
test/tb.sv
